// ===== hw/rtl/sgdm_pkg.sv =====
// shared types, constants and saturation helpers for the sgd momentum update
`timescale 1ns / 1ps
`default_nettype none

package sgdm_pkg;

    // value format and rate format
    localparam int VALUE_BITS = 32;
    localparam int RATE_FRAC  = 16;
    localparam int RATE_W     = RATE_FRAC + 1;
    localparam int LR_W       = RATE_FRAC;
    localparam int PROD_W     = VALUE_BITS + RATE_W + 1;
    localparam int SCALED_W   = PROD_W - RATE_FRAC;
    localparam int GUARD_W    = SCALED_W - VALUE_BITS + 1;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [RATE_W-1:0]            t_rate;

    localparam t_rate  RATE_ONE = t_rate'(1) << RATE_FRAC;
    localparam t_value VAL_MAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam t_value VAL_MIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARNING_RATE = 3'd0,
        CFG_DAMPENING     = 3'd1,
        CFG_MOMENTUM      = 3'd2,
        CFG_NESTEROV      = 3'd3,
        CFG_FIRST_STEP    = 3'd4
    } t_cfg_idx;

    // request and response payloads
    typedef struct packed {
        t_value weight_in;
        t_value accum_in;
        t_value gradient_in;
        logic   last_in;
    } t_in;

    typedef struct packed {
        t_value weight_out;
        t_value accum_out;
        logic   last_out;
        logic   init_done;
    } t_out;

    // drop the rate fraction (floor) and clamp to the value range
    function automatic t_value sat_scale(input logic signed [PROD_W-1:0] p);
        logic [SCALED_W-1:0] s;
        logic [GUARD_W-1:0]  g;
        s = p[PROD_W-1:RATE_FRAC];
        g = s[SCALED_W-1:VALUE_BITS-1];
        if (g == '0 || g == '1) begin
            return t_value'(s[VALUE_BITS-1:0]);
        end
        return s[SCALED_W-1] ? VAL_MIN : VAL_MAX;
    endfunction

    // saturating add
    function automatic t_value sat_add(input t_value a, input t_value b);
        logic [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} + {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
        end
        return t_value'(s[VALUE_BITS-1:0]);
    endfunction

    // saturating subtract
    function automatic t_value sat_sub(input t_value a, input t_value b);
        logic [VALUE_BITS:0] s;
        s = {a[VALUE_BITS-1], a} - {b[VALUE_BITS-1], b};
        if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            return s[VALUE_BITS] ? VAL_MIN : VAL_MAX;
        end
        return t_value'(s[VALUE_BITS-1:0]);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sgd_momentum_update.sv =====
// sgd momentum update: six-stage pipeline, config registers, handshakes
// throughput: one request per cycle; every stage moves on each cycle unless the output stalls
// stages: momentum/damp products, blend, look-ahead product, delta, lr product, weight
// each stage holds its slot until the next frees, so a stall drops nothing
// reset (synchronous, active low): pipeline empty, rates zero, first_step set
`timescale 1ns / 1ps
`default_nettype none

module sgd_momentum_update
    import sgdm_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in                  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out                      o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [RATE_W-1:0]    i_cfg_data
);

    localparam int STAGES = 6;

    typedef struct packed {
        t_value weight;
        t_value accum;
        t_value term;
        logic   last;
    } t_stage;

    logic [LR_W-1:0] r_lr;
    t_rate           r_damp;
    t_rate           r_mom;
    logic            r_nesterov;
    logic            r_first;

    logic [STAGES-1:0] r_valid;
    logic [STAGES-1:0] w_en;
    t_stage            r_stage [STAGES-1];
    t_stage            n_stage [STAGES-1];
    t_out              r_out;
    t_out              n_out;

    t_rate  w_gain;
    logic   w_plain;
    t_value w_acc_mom;
    t_value w_grad_gain;
    t_value w_look;
    t_value w_step;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lr       <= '0;
            r_damp     <= '0;
            r_mom      <= '0;
            r_nesterov <= 1'b0;
            r_first    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LEARNING_RATE: r_lr       <= i_cfg_data[LR_W-1:0];
                CFG_DAMPENING:     r_damp     <= i_cfg_data;
                CFG_MOMENTUM:      r_mom      <= i_cfg_data;
                CFG_NESTEROV:      r_nesterov <= i_cfg_data[0];
                CFG_FIRST_STEP:    r_first    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // gradient gain 1 - dampening, dampening clamped at one
    assign w_gain  = (r_damp > RATE_ONE) ? '0 : t_rate'(RATE_ONE - r_damp);
    assign w_plain = !r_first && (r_mom == '0);

    // stall chain: a stage loads when it is empty or its successor loads
    always_comb begin
        w_en[STAGES-1] = !r_valid[STAGES-1] || i_out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_valid[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_valid[STAGES-1];
    assign o_out_data  = r_out;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (w_en[0]) begin
                r_valid[0] <= i_in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
    end

    // stage 1 products: accumulator by momentum, gradient by gain
    sgdm_rate_mul u_mul_acc (
        .i_clk    (i_clk),
        .i_en     (w_en[0]),
        .i_value  (i_in_data.accum_in),
        .i_rate   (r_mom),
        .o_scaled (w_acc_mom)
    );

    sgdm_rate_mul u_mul_grad (
        .i_clk    (i_clk),
        .i_en     (w_en[0]),
        .i_value  (i_in_data.gradient_in),
        .i_rate   (w_gain),
        .o_scaled (w_grad_gain)
    );

    // stage 3 product: new accumulator by momentum for the look-ahead
    sgdm_rate_mul u_mul_look (
        .i_clk    (i_clk),
        .i_en     (w_en[2]),
        .i_value  (r_stage[1].accum),
        .i_rate   (r_mom),
        .o_scaled (w_look)
    );

    // stage 5 product: delta by learning rate
    sgdm_rate_mul u_mul_step (
        .i_clk    (i_clk),
        .i_en     (w_en[4]),
        .i_value  (r_stage[3].term),
        .i_rate   (t_rate'(r_lr)),
        .o_scaled (w_step)
    );

    // next values of the stage registers
    always_comb begin
        // stage 1: capture the request
        n_stage[0].weight = i_in_data.weight_in;
        n_stage[0].accum  = i_in_data.accum_in;
        n_stage[0].term   = i_in_data.gradient_in;
        n_stage[0].last   = i_in_data.last_in;

        // stage 2: accumulator blend
        n_stage[1] = r_stage[0];
        if (r_first) begin
            n_stage[1].accum = r_stage[0].term;
        end else if (!w_plain) begin
            n_stage[1].accum = sat_add(w_acc_mom, w_grad_gain);
        end

        // stage 3: wait on the look-ahead product
        n_stage[2] = r_stage[1];

        // stage 4: delta, gradient in plain sgd
        n_stage[3] = r_stage[2];
        if (w_plain) begin
            n_stage[3].term = r_stage[2].term;
        end else if (r_nesterov) begin
            n_stage[3].term = sat_add(w_look, r_stage[2].term);
        end else begin
            n_stage[3].term = r_stage[2].accum;
        end

        // stage 5: wait on the learning rate product
        n_stage[4] = r_stage[3];

        // stage 6: weight update
        n_out.weight_out = sat_sub(r_stage[4].weight, w_step);
        n_out.accum_out  = r_stage[4].accum;
        n_out.last_out   = r_stage[4].last;
        n_out.init_done  = r_first && r_stage[4].last;
    end

    // stage payload registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES - 1; k++) begin
            if (w_en[k]) begin
                r_stage[k] <= n_stage[k];
            end
        end
        if (w_en[STAGES-1]) begin
            r_out <= n_out;
        end
    end

    // a blocked input means every stage holds an item
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_valid))
        else $error("input blocked while the pipeline has a free slot");

    // an accepted request occupies the first stage
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_valid[0])
        else $error("accepted request did not enter the first stage");

    // init_done only while the first step is selected
    a_init_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !r_first) |-> !o_out_data.init_done)
        else $error("init_done raised outside the first step");

endmodule

`default_nettype wire

// ===== hw/rtl/sgdm_rate_mul.sv =====
// registered value-by-rate multiplier with floor scaling and saturation
`timescale 1ns / 1ps
`default_nettype none

module sgdm_rate_mul
    import sgdm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_en,
    input  wire t_value i_value,
    input  wire t_rate  i_rate,
    output t_value      o_scaled
);

    logic signed [RATE_W:0]   w_rate;
    logic signed [PROD_W-1:0] r_prod;

    // rate is unsigned, widen with a zero sign bit
    assign w_rate = {1'b0, i_rate};

    // product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_value * w_rate;
        end
    end

    // scale and clamp after the register
    assign o_scaled = sat_scale(r_prod);

endmodule

`default_nettype wire
